FILE: sv/selective_repeat_sender_defines.svh
// Assertion macros used by the selective-repeat sender RTL.
`ifndef SELECTIVE_REPEAT_SENDER_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_DEFINES_SVH

// Check an expression on every clock edge outside reset.
`define SRS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("srs invariant violated");

// Check that a condition implies another one in the same cycle.
`define SRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srs implication violated");

// Check that a condition implies another one in the next cycle.
`define SRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srs next-cycle implication violated");

`endif

FILE: sv/srs_pkg.sv
// Types, constants and codes of the selective-repeat sender.
package srs_pkg;

  localparam int MAX_FRAMES   = 256;
  localparam int MAX_WINDOW   = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int WIN_LIM      = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;

  localparam int ADDR_W  = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int WIN_W   = 5;
  localparam int SEQ_W   = 8;
  localparam int POS_W   = (WIN_LIM > 1) ? $clog2(WIN_LIM) : 1;
  localparam int SCAN_W  = $clog2(WIN_LIM + 1);
  localparam int FC_W    = 9;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Event codes
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic REG_WINDOW_SIZE = 1'b1;

  localparam logic [FC_W-1:0]  FRAME_COUNT_RST = 9'd10;
  localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 5'd4;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SEQ_W-1:0] ack_seq;
  } in_t;

  typedef struct packed {
    logic             frame_valid;
    logic [SEQ_W-1:0] send_seq;
    logic             is_retransmit;
    logic             ack_ignored;
    logic             all_sent;
    logic             last;
  } out_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [CNT_W-1:0] frame_count;
    logic [WIN_W-1:0] window_size;
  } cfg_t;

  // Ack bitmap access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: sv/srs_cfg.sv
// APB configuration registers with clamping of frame count and window size.
module srs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srs_pkg::PADDR_W-1:0] paddr,
  input  logic [srs_pkg::PDATA_W-1:0] pwdata,
  output logic [srs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output srs_pkg::cfg_t               cfg
);
  import srs_pkg::*;

  logic [FC_W-1:0]  frame_count_r;
  logic [WIN_W-1:0] window_size_r;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // Registers sit at word addresses; the byte offset bits are not decoded
  assign reg_idx = paddr[2];

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      window_size_r <= WINDOW_SIZE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_COUNT: frame_count_r <= pwdata[FC_W-1:0];
        REG_WINDOW_SIZE: window_size_r <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back raw register values
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FRAME_COUNT: prdata = PDATA_W'(frame_count_r);
      REG_WINDOW_SIZE: prdata = PDATA_W'(window_size_r);
      default: prdata = '0;
    endcase
  end

  // Clamp to the supported ranges
  always_comb begin
    if (frame_count_r == '0) begin
      cfg.frame_count = CNT_W'(1);
    end else if (CNT_W'(frame_count_r) > CNT_W'(MAX_FRAMES)) begin
      cfg.frame_count = CNT_W'(MAX_FRAMES);
    end else begin
      cfg.frame_count = CNT_W'(frame_count_r);
    end
    if (window_size_r == '0) begin
      cfg.window_size = WIN_W'(1);
    end else if (window_size_r > WIN_W'(WIN_LIM)) begin
      cfg.window_size = WIN_W'(WIN_LIM);
    end else begin
      cfg.window_size = window_size_r;
    end
  end

endmodule

FILE: sv/srs_ackmap.sv
// Acknowledge bitmap: one flag per frame in a single-port-write, registered-read memory.
module srs_ackmap (
  input  logic                clk,
  input  srs_pkg::mem_req_t   req,
  output logic                rd_data
);
  import srs_pkg::*;

  logic mem [MAX_FRAMES];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

FILE: sv/srs_ctrl.sv
// Event sequencer: window bookkeeping, base slide, timeout scan and result generation.
`include "selective_repeat_sender_defines.svh"

module srs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  srs_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  srs_pkg::in_t      in_data,
  output srs_pkg::mem_req_t mem_req,
  input  logic              rd_data,
  output logic              emit_valid,
  input  logic              emit_ready,
  output srs_pkg::out_t     emit_data
);
  import srs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SLIDE_RD  = 7'b0000010,
    ST_SLIDE_CHK = 7'b0000100,
    ST_FILL      = 7'b0001000,
    ST_SCAN      = 7'b0010000,
    ST_TO_EMIT   = 7'b0100000,
    ST_SPARE     = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    base_r, base_nxt;
  logic [CNT_W-1:0]    nts_r, nts_nxt;
  logic                ign_r, ign_nxt;
  logic [WIN_LIM-1:0]  pend_r, pend_nxt;
  logic [SCAN_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [POS_W-1:0]    rd_pos_r, rd_pos_nxt;

  logic                in_fire;
  logic                emit_fire;
  logic [CNT_W-1:0]    ack_ext;
  logic                ack_hit;
  logic [CNT_W-1:0]    outst;
  logic [CNT_W-1:0]    win_ext;
  logic                can_send;
  logic [CNT_W-1:0]    nts_inc;
  logic                more_after;
  logic                all_sent;
  logic [WIN_LIM-1:0]  pend_low;
  logic [WIN_LIM-1:0]  pend_rest;
  logic [POS_W-1:0]    low_idx;
  logic                scan_re;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = emit_valid && emit_ready;

  // Window arithmetic
  assign ack_ext    = CNT_W'(in_data.ack_seq);
  assign ack_hit    = (ack_ext >= base_r) && (ack_ext < nts_r);
  assign outst      = nts_r - base_r;
  assign win_ext    = CNT_W'(cfg.window_size);
  assign can_send   = (nts_r < cfg.frame_count) && (outst < win_ext);
  assign nts_inc    = nts_r + CNT_W'(1);
  assign more_after = (nts_inc < cfg.frame_count) && ((nts_inc - base_r) < win_ext);
  assign all_sent   = (base_r >= cfg.frame_count);
  assign scan_re    = (CNT_W'(scan_idx_r) < outst);

  // Pick the lowest pending resend
  assign pend_low  = pend_r & (~pend_r + WIN_LIM'(1));
  assign pend_rest = pend_r & (pend_r - WIN_LIM'(1));
  always_comb begin
    low_idx = '0;
    for (int j = 0; j < WIN_LIM; j++) begin
      if (pend_low[j]) begin
        low_idx = low_idx | POS_W'(j);
      end
    end
  end

  // Bitmap accesses; a read never shares a cycle with a write
  always_comb begin
    mem_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        mem_req.we    = in_fire && (in_data.req_type == REQ_ACK) && ack_hit;
        mem_req.waddr = in_data.ack_seq;
        mem_req.wdata = 1'b1;
      end
      ST_SLIDE_RD: begin
        mem_req.re    = (base_r < nts_r);
        mem_req.raddr = base_r[ADDR_W-1:0];
      end
      ST_FILL: begin
        // clear the flag of each frame as it enters the window
        mem_req.we    = emit_fire && can_send;
        mem_req.waddr = nts_r[ADDR_W-1:0];
        mem_req.wdata = 1'b0;
      end
      ST_SCAN: begin
        mem_req.re    = scan_re;
        mem_req.raddr = base_r[ADDR_W-1:0] + ADDR_W'(scan_idx_r);
      end
      default: ;
    endcase
  end

  // Result beats
  always_comb begin
    emit_valid = 1'b0;
    emit_data  = '0;
    emit_data.ack_ignored = ign_r;
    emit_data.all_sent    = all_sent;
    unique case (state_r)
      ST_FILL: begin
        emit_valid = 1'b1;
        if (can_send) begin
          emit_data.frame_valid = 1'b1;
          emit_data.send_seq    = nts_r[SEQ_W-1:0];
          emit_data.last        = !more_after;
        end else begin
          emit_data.last = 1'b1;
        end
      end
      ST_TO_EMIT: begin
        emit_valid = 1'b1;
        if (pend_r != '0) begin
          emit_data.frame_valid   = 1'b1;
          emit_data.send_seq      = base_r[SEQ_W-1:0] + SEQ_W'(low_idx);
          emit_data.is_retransmit = 1'b1;
          emit_data.last          = (pend_rest == '0);
        end else begin
          emit_data.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    nts_nxt      = nts_r;
    ign_nxt      = ign_r;
    pend_nxt     = pend_r;
    scan_idx_nxt = scan_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_pos_nxt   = rd_pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ign_nxt = 1'b0;
          unique case (in_data.req_type)
            REQ_START: state_nxt = ST_FILL;
            REQ_ACK: begin
              if (ack_hit) begin
                state_nxt = ST_SLIDE_RD;
              end else begin
                ign_nxt   = 1'b1;
                state_nxt = ST_FILL;
              end
            end
            REQ_TIMEOUT: begin
              scan_idx_nxt = '0;
              pend_nxt     = '0;
              state_nxt    = ST_SCAN;
            end
            default: begin
              // unknown event: one empty result
              pend_nxt  = '0;
              state_nxt = ST_TO_EMIT;
            end
          endcase
        end
      end
      ST_SLIDE_RD: begin
        state_nxt = (base_r < nts_r) ? ST_SLIDE_CHK : ST_FILL;
      end
      ST_SLIDE_CHK: begin
        if (rd_data) begin
          base_nxt  = base_r + CNT_W'(1);
          state_nxt = ST_SLIDE_RD;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (emit_fire) begin
          if (can_send) begin
            nts_nxt = nts_inc;
          end
          if (emit_data.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        // stream reads over the outstanding range, collect unacked frames
        rd_vld_nxt = scan_re;
        rd_pos_nxt = scan_idx_r[POS_W-1:0];
        if (scan_re) begin
          scan_idx_nxt = scan_idx_r + SCAN_W'(1);
        end
        if (rd_vld_r) begin
          pend_nxt[rd_pos_r] = !rd_data;
        end
        if (!scan_re && !rd_vld_r) begin
          state_nxt = ST_TO_EMIT;
        end
      end
      ST_TO_EMIT: begin
        if (emit_fire) begin
          pend_nxt = pend_rest;
          if (emit_data.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      base_r     <= '0;
      nts_r      <= '0;
      ign_r      <= 1'b0;
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      base_r     <= base_nxt;
      nts_r      <= nts_nxt;
      ign_r      <= ign_nxt;
      scan_idx_r <= scan_idx_nxt;
      rd_vld_r   <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r   <= pend_nxt;
    rd_pos_r <= rd_pos_nxt;
  end

  `SRS_ASSERT_ALWAYS(a_base_le_nts, base_r <= nts_r)
  `SRS_ASSERT_ALWAYS(a_outst_bound, outst <= CNT_W'(WIN_LIM))
  `SRS_ASSERT_ALWAYS(a_no_rw_overlap, !(mem_req.we && mem_req.re))
  `SRS_ASSERT_IMPL(a_slide_in_range, state_r == ST_SLIDE_CHK, base_r < nts_r)
  `SRS_ASSERT_NEXT(a_last_ends_event, emit_fire && emit_data.last, state_r == ST_IDLE)

endmodule

FILE: sv/srs_outbuf.sv
// One-entry output register between the sequencer and the result channel.
module srs_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          emit_valid,
  output logic          emit_ready,
  input  srs_pkg::out_t emit_data,
  output logic          out_valid,
  input  logic          out_ready,
  output srs_pkg::out_t out_data
);
  import srs_pkg::*;

  logic out_valid_r;
  out_t out_data_r;

  assign emit_ready = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Load a new beat when the slot is free or drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_data_r <= emit_data;
    end
  end

endmodule

FILE: sv/selective_repeat_sender.sv
// Top level of the selective-repeat sender.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_data   (srs_pkg::in_t)
//  out_     output     out_valid / out_ready  out_data  (srs_pkg::out_t)
//  cfg      APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// Start: enter the fill state, then one beat per new frame (or one empty beat).
// Ack: as start, but an ack in the window first slides the base; each bitmap entry is
// read in SLIDE_RD and checked in SLIDE_CHK (registered read) until an unacked entry or
// the next index is reached. Timeout: scan the outstanding range of the bitmap, then
// one beat per resend (or one empty beat).
// Reset needs no clearing pass: each bitmap entry is cleared as its frame is sent.
// Result beats wait in an output register; a stalled out_ready holds the sequencer.
module selective_repeat_sender (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  srs_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output srs_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srs_pkg::PADDR_W-1:0] paddr,
  input  logic [srs_pkg::PDATA_W-1:0] pwdata,
  output logic [srs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import srs_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  logic     rd_data;
  logic     emit_valid;
  logic     emit_ready;
  out_t     emit_data;

  srs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srs_ackmap u_ackmap (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  srs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data)
  );

  srs_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
